@@ rtl/core/lse_pkg.sv @@
`default_nettype none
package lse_pkg;

  localparam int unsigned MaxTerms = 64;
  localparam int unsigned TermW = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW = 40;
  localparam int unsigned DivW = 64;
  localparam int unsigned DivCntW = 6;

  localparam logic [DataW-1:0] PrecisionReset = 32'd1678;
  localparam logic [TermW-1:0] MaxTermsReset = 7'd64;
  localparam logic [TermW-1:0] MaxTermsLimit = 7'(MaxTerms);

  localparam logic CfgPrecision = 1'b0;
  localparam logic CfgMaxTerms = 1'b1;

  typedef struct packed {
    logic start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/lse_divider.sv @@
`default_nettype none
module lse_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire lse_pkg::div_req_t req,
  output lse_pkg::div_rsp_t rsp
);

  logic busy;
  logic done;
  logic [lse_pkg::DivCntW-1:0] count;
  logic [lse_pkg::DivW-1:0] quo;
  logic [lse_pkg::DivW-1:0] rem;
  logic [lse_pkg::DivW-1:0] dsr;
  logic [lse_pkg::DivW:0] shifted;
  logic [lse_pkg::DivW:0] diff;

  assign shifted = {rem, quo[lse_pkg::DivW-1]};
  assign diff = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == lse_pkg::DivCntW'(lse_pkg::DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!diff[lse_pkg::DivW]) begin
        rem <= diff[lse_pkg::DivW-1:0];
        quo <= {quo[lse_pkg::DivW-2:0], 1'b1};
      end else begin
        rem <= shifted[lse_pkg::DivW-1:0];
        quo <= {quo[lse_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("divider done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start |=> busy || rsp.done) else $error("divider dropped work");
`endif

endmodule
`default_nettype wire

@@ rtl/core/log_series_evaluator_unit.sv @@
// Channel    Direction  Handshake          Payload
// x input    in         in_valid/in_stall  x_value
// result     out        out_valid/out_stall log_value, precision_reached, terms_used
// config     in         cfg_valid/cfg_ready cfg_index, cfg_data
// The 64-step shift-subtract divider sets the time; it is shared by the ratio and each term.
// The ratio is divided and then squared; each term is one division and a test, with a multiply before the next term.
// Reset is synchronous on rst and restores the register defaults.
// A stalled result holds; the next item is accepted only after the result transfer.
`default_nettype none
module log_series_evaluator_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [31:0] x_value,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] log_value,
  output logic precision_reached,
  output logic [6:0] terms_used,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDIV  = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_TDIV  = 7'b0001000,
    S_TEST  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [31:0] precision_limit;
  logic [6:0] max_terms;
  logic [6:0] limit;
  logic negative;
  logic [30:0] r2;
  logic [31:0] p;
  logic [6:0] n;
  logic [6:0] count;
  logic [lse_pkg::SumW-1:0] sum;
  logic [lse_pkg::SumW-1:0] term;
  logic waiting;
  lse_pkg::div_req_t dreq;
  lse_pkg::div_rsp_t drsp;
  logic [31:0] xa;
  logic [32:0] num;
  logic [30:0] mul_b;
  logic [62:0] prod;
  logic [lse_pkg::SumW-1:0] mag;
  logic [lse_pkg::SumW-1:0] tmag;

  lse_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign xa = (x_value == 32'd0) ? 32'd1 : x_value;
  assign num = (xa < 32'h10000) ? 33'(32'h10000 - xa) : 33'(xa - 32'h10000);
  assign mul_b = (state == S_SQ) ? p[30:0] : r2;
  assign prod = 63'(p) * 63'(mul_b);
  assign tmag = (term << 1) >> 7;
  assign mag = (sum << 1) >> 7;

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = {num, 31'd0};
    dreq.divisor = 64'(xa) + 64'h10000;
    if (state == S_IDLE) begin
      dreq.start = in_valid;
    end else if (state == S_TDIV && !waiting) begin
      dreq.start = 1'b1;
      dreq.dividend = 64'(p);
      dreq.divisor = 64'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      precision_limit <= lse_pkg::PrecisionReset;
      max_terms <= lse_pkg::MaxTermsReset;
      waiting <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          lse_pkg::CfgPrecision: precision_limit <= cfg_data;
          lse_pkg::CfgMaxTerms: max_terms <= cfg_data[6:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            negative <= xa < 32'h10000;
            limit <= (max_terms == 7'd0) ? 7'd1 :
                     (max_terms > lse_pkg::MaxTermsLimit) ? lse_pkg::MaxTermsLimit : max_terms;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (drsp.done) begin
            p <= drsp.quotient[31:0];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          r2 <= 31'(prod >> 31);
          n <= 7'd1;
          count <= 7'd0;
          sum <= '0;
          waiting <= 1'b0;
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (drsp.done) begin
            waiting <= 1'b0;
            term <= 40'(drsp.quotient);
            sum <= sum + 40'(drsp.quotient);
            count <= count + 7'd1;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          precision_reached <= tmag < 40'(precision_limit);
          if (tmag < 40'(precision_limit) || count >= limit) begin
            terms_used <= count;
            if (negative) begin
              log_value <= (mag > 40'h80000000) ? 32'sh80000000 : -$signed(mag[31:0]);
            end else begin
              log_value <= (mag > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
            end
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p <= 32'(prod >> 31);
          n <= n + 7'd2;
          state <= S_TDIV;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(log_value)) else $error("result changed");
  a_terms_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> terms_used != 7'd0 && terms_used <= limit) else $error("term count");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepted while result pending");
`endif

endmodule
`default_nettype wire

@@ dv/lse_checker.sv @@
`default_nettype none
module lse_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic [31:0] x_value,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic signed [31:0] log_value,
  input  wire logic precision_reached,
  input  wire logic [6:0] terms_used,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [31:0] cfg_data,
  output int errors,
  output int pending
);

  typedef struct packed {
    logic [31:0] value;
    logic reached;
    logic [6:0] terms;
  } log_result_t;

  logic [31:0] eps;
  logic [6:0] term_cap;
  log_result_t expected_logs[$];

  function automatic log_result_t compute_log(logic [31:0] xin);
    logic [63:0] x, num, den, rm, r2, p, sum, term, mag;
    logic neg, hit;
    int unsigned lim, cnt, n;
    log_result_t res;
    x = {32'd0, xin};
    if (x == 0) x = 1;
    lim = term_cap;
    if (lim == 0) lim = 1;
    if (lim > lse_pkg::MaxTerms) lim = lse_pkg::MaxTerms;
    neg = x < 64'd65536;
    num = neg ? 64'd65536 - x : x - 64'd65536;
    den = x + 64'd65536;
    rm = (num << 31) / den;
    r2 = (rm * rm) >> 31;
    p = rm;
    sum = 0;
    cnt = 0;
    n = 1;
    hit = 1'b0;
    forever begin
      term = p / n;
      sum += term;
      cnt++;
      hit = ((term << 1) >> 7) < {32'd0, eps};
      if (hit || cnt >= lim) break;
      p = (p * r2) >> 31;
      n += 2;
    end
    mag = (sum << 1) >> 7;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      res.value = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      res.value = mag[31:0];
    end
    res.reached = hit;
    res.terms = cnt[6:0];
    return res;
  endfunction

  assign pending = expected_logs.size();

  always @(posedge clk) begin
    log_result_t want;
    if (rst) begin
      eps <= lse_pkg::PrecisionReset;
      term_cap <= lse_pkg::MaxTermsReset;
      expected_logs.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lse_pkg::CfgPrecision) eps <= cfg_data;
        else term_cap <= cfg_data[6:0];
      end
      if (in_valid && !in_stall) expected_logs.push_back(compute_log(x_value));
      if (out_valid && !out_stall) begin
        if (expected_logs.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer: %h", log_value);
          errors <= errors + 1;
        end else begin
          want = expected_logs.pop_front();
          if (want != {log_value, precision_reached, terms_used}) begin
            if (errors < 10)
              $display("mismatch: expected %h/%b/%0d got %h/%b/%0d", want.value,
                       want.reached, want.terms, log_value, precision_reached, terms_used);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ dv/tb_log_series_evaluator_unit.sv @@
`default_nettype none
module tb_log_series_evaluator_unit;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [31:0] x_value = 32'd0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = lse_pkg::CfgPrecision;
  logic [31:0] cfg_data = 32'd0;
  wire logic in_stall, out_valid, precision_reached, cfg_ready;
  wire logic signed [31:0] log_value;
  wire logic [6:0] terms_used;
  int errors, pending;
  int stall_left = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  log_series_evaluator_unit DUT (.*);
  lse_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_x(logic [31:0] x);
    int g;
    g = gap_len();
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_value <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_x();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h0001_0000 + $urandom_range(0, 4096) - 2048;
      2: return $urandom_range(0, 65535);
      3: return $urandom_range(1, 32'h0040_0000);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!stim_done && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [31:0] edges[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    edges = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0002_0000, 32'h0002_B7E1,
              32'h5555_AAAA, 32'hAAAA_5555};
    foreach (edges[i]) send_x(edges[i]);
    drain();
    write_reg(lse_pkg::CfgPrecision, 32'd0);
    write_reg(lse_pkg::CfgMaxTerms, 32'd0);
    send_x(32'h0003_0000);
    send_x(32'h0000_4000);
    drain();
    write_reg(lse_pkg::CfgMaxTerms, 32'd127);
    send_x(32'hFFFF_FFFF);
    send_x(32'd1);
    drain();
    write_reg(lse_pkg::CfgPrecision, 32'hFFFF_FFFF);
    write_reg(lse_pkg::CfgMaxTerms, 32'd1);
    send_x(32'h0000_0100);
    send_x(32'h00FF_0000);
    drain();
    write_reg(lse_pkg::CfgPrecision, 32'd1678);
    write_reg(lse_pkg::CfgMaxTerms, 32'd64);
    fork
      begin
        hold_long = 1'b1;
        repeat (12000) @(posedge clk);
        hold_long = 1'b0;
      end
      repeat (4) send_x(rand_x());
    join
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(lse_pkg::CfgPrecision, (ph == 4) ? 32'd1 : $urandom() >> $urandom_range(8, 31));
      write_reg(lse_pkg::CfgMaxTerms, 32'($urandom_range(0, 80)));
      for (int k = 0; k < 50; k++) send_x(rand_x());
    end
    stim_done = 1'b1;
    drain();
    if (errors == 0 && pending == 0) $display("tb_log_series_evaluator_unit: done, clean");
    else $display("tb_log_series_evaluator_unit: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_log_series_evaluator_unit: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
